/* rtl/core/sbpa_pkg.sv */
// Shared types and codes of the shared-buffer push-out admission block.
package sbpa_pkg;

  localparam int NUM_CLASSES = 5;
  localparam int CLS_W       = 3;
  localparam int OP_W        = 2;
  localparam int SEL_W       = 4;
  localparam int STS_W       = 3;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int STAT_W      = 32;
  localparam int OCC_W       = 11;

  typedef logic [CLS_W-1:0] cls_t;
  typedef logic [STS_W-1:0] sts_t;
  typedef logic [CFG_W-1:0] cfg_word_t;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STAT = 2'd2;

  // Result status codes.
  localparam sts_t STS_STORED  = 3'd0;
  localparam sts_t STS_EVICTED = 3'd1;
  localparam sts_t STS_DROPPED = 3'd2;
  localparam sts_t STS_DEQUEUED = 3'd3;
  localparam sts_t STS_EMPTY   = 3'd4;
  localparam sts_t STS_STAT    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE5   = 3'd5;

endpackage

/* rtl/core/shared_buffer_pushout_admission.sv */
// Top level of the shared-buffer push-out admission block.
//
// Five FIFO queues of packet handles share one linked-list buffer. Requests
// arrive on the s_ stream (op in s_tuser), one result per request leaves on
// the m_ stream (status in m_tuser). Enqueues beyond capacity may push out the
// tail of another class, whose handle is returned for freeing.
// Each request is accepted in the idle state, then passes a decision state
// that also issues the link and handle memory reads, then a write-back
// state once the registered read data is back. s_tready is high only in the
// idle state, so a new request is accepted only after the last one has been
// written back; the result is registered in the output register.
// If the receiver stalls, the result stays in the output register; the next
// request is still accepted and waits in its write-back cycle until the
// output register is free.
// Reset (synchronous, rst high) empties all queues, clears counters and
// loads capacity 1000 and shares of 200. Memories need no clearing: fresh
// slots are handed out by a fill counter before the free list is used.
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once.
module shared_buffer_pushout_admission import sbpa_pkg::*; #(
  parameter int BUFFER_DEPTH = 1024,
  parameter int HANDLE_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // queue_class, packet_handle, stat_select (lowest first)
  input  logic [((CLS_W+HANDLE_BITS+SEL_W+7)/8)*8-1:0] s_tdata,
  // op
  input  logic [OP_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // evicted_class, evicted_handle, dequeued_handle, stat_value, total_occupancy
  output logic [((CLS_W+2*HANDLE_BITS+STAT_W+OCC_W+7)/8)*8-1:0] m_tdata,
  // status
  output logic [STS_W-1:0] m_tuser,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW     = $clog2(BUFFER_DEPTH);
  localparam int CNTW   = $clog2(BUFFER_DEPTH + 1);
  localparam int CMPW   = (CNTW > CFG_W) ? CNTW : CFG_W;
  localparam int OUT_W  = CLS_W + 2*HANDLE_BITS + STAT_W + OCC_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  localparam logic [2:0] A_NONE   = 3'd0;
  localparam logic [2:0] A_APPEND = 3'd1;
  localparam logic [2:0] A_EVICT  = 3'd2;
  localparam logic [2:0] A_DROP   = 3'd3;
  localparam logic [2:0] A_DEQ    = 3'd4;
  localparam logic [2:0] A_PULL   = 3'd5;

  logic [1:0] state;

  // Request registers.
  logic [OP_W-1:0]        in_op;
  cls_t                   in_cls;
  logic [HANDLE_BITS-1:0] in_h;
  logic [SEL_W-1:0]       in_sel;

  // Configuration.
  cfg_word_t capacity;
  cfg_word_t share [NUM_CLASSES];

  // Queue state.
  logic [AW-1:0]   qhead [NUM_CLASSES];
  logic [AW-1:0]   qtail [NUM_CLASSES];
  logic [CNTW-1:0] qcnt  [NUM_CLASSES];
  logic [CNTW-1:0] total;
  logic [CNTW-1:0] fresh;
  logic [AW-1:0]   free_head;
  logic [STAT_W-1:0] drops    [NUM_CLASSES];
  logic [STAT_W-1:0] arrivals [NUM_CLASSES];
  logic [STAT_W-1:0] pulls;

  // Memories.
  logic [HANDLE_BITS-1:0] hs_mem [BUFFER_DEPTH];
  logic [AW-1:0]          pl_mem [BUFFER_DEPTH];
  logic [AW-1:0]          nl_mem [BUFFER_DEPTH];
  logic [HANDLE_BITS-1:0] hs_rd;
  logic [AW-1:0]          pl_rd;
  logic [AW-1:0]          nl_rd;
  logic [AW-1:0]          slot_ra;
  logic [AW-1:0]          nl_ra;
  logic                   slot_we;
  logic [AW-1:0]          slot_wa;
  logic                   nl_we;
  logic [AW-1:0]          nl_wa;
  logic [AW-1:0]          nl_wd;

  // Decision registers.
  logic [2:0]        act;
  sts_t              sts;
  logic [2:0]        cidx;
  logic [2:0]        vic;
  logic [STAT_W-1:0] stat_val;

  // Output register.
  sts_t                   o_sts;
  cls_t                   o_evc;
  logic [HANDLE_BITS-1:0] o_evh;
  logic [HANDLE_BITS-1:0] o_dqh;
  logic [STAT_W-1:0]      o_stat;
  logic [OCC_W-1:0]       o_occ;

  // Decision logic.
  logic              cls_ok;
  logic [2:0]        c_idx;
  logic [CNTW-1:0]   cnt_c;
  logic [CMPW-1:0]   cap_eff;
  logic              has_room;
  logic              at_share;
  logic              vic_found;
  logic [2:0]        vic_sel;
  logic [2:0]        act_next;
  sts_t              sts_next;
  logic [STAT_W-1:0] stat_next;

  // Write-back logic.
  logic            out_free;
  logic            from_fresh;
  logic [AW-1:0]   new_slot;
  logic [CNTW-1:0] total_next;

  always_comb begin
    cls_ok  = in_cls < CLS_W'(NUM_CLASSES);
    c_idx   = cls_ok ? in_cls : 3'd0;
    cnt_c   = qcnt[c_idx];
    cap_eff = (CMPW'(capacity) < CMPW'(BUFFER_DEPTH)) ? CMPW'(capacity) : CMPW'(BUFFER_DEPTH);
    has_room = CMPW'(total) < cap_eff;
    at_share = CMPW'(cnt_c) >= CMPW'(share[c_idx]);
    vic_found = 1'b0;
    vic_sel   = 3'd0;
    for (int v = NUM_CLASSES - 1; v >= 1; v--) begin
      if (!vic_found && (3'(v) != c_idx) && (CMPW'(qcnt[v]) > CMPW'(share[v]))) begin
        vic_found = 1'b1;
        vic_sel   = 3'(v);
      end
    end
    if (!vic_found && (c_idx != 3'd0) && (qcnt[0] != '0)) begin
      vic_found = 1'b1;
      vic_sel   = 3'd0;
    end

    act_next  = A_NONE;
    sts_next  = STS_STAT;
    stat_next = '0;
    case (in_op)
      OP_ENQ: begin
        sts_next = STS_DROPPED;
        if (cls_ok) begin
          if (has_room) begin
            act_next = A_APPEND;
            sts_next = STS_STORED;
          end else if (!at_share && vic_found) begin
            act_next = A_EVICT;
            sts_next = STS_EVICTED;
          end else begin
            act_next = A_DROP;
          end
        end
      end
      OP_DEQ: begin
        sts_next = STS_EMPTY;
        if (cls_ok) begin
          if (cnt_c == '0) begin
            act_next = A_PULL;
          end else begin
            act_next = A_DEQ;
            sts_next = STS_DEQUEUED;
          end
        end
      end
      OP_STAT: begin
        case (in_sel) inside
          [4'd0:4'd4]:   stat_next = STAT_W'(qcnt[3'(in_sel)]);
          [4'd5:4'd9]:   stat_next = drops[3'(in_sel - 4'd5)];
          [4'd10:4'd14]: stat_next = arrivals[3'(in_sel - 4'd10)];
          default:       stat_next = pulls;
        endcase
      end
      default: begin
        stat_next = '0;
      end
    endcase

    slot_ra = (in_op == OP_DEQ) ? qhead[c_idx] : qtail[vic_sel];
    nl_ra   = (in_op == OP_DEQ) ? qhead[c_idx] : free_head;
  end

  always_comb begin
    out_free   = !m_tvalid || m_tready;
    from_fresh = fresh < CNTW'(BUFFER_DEPTH);
    new_slot   = (act == A_EVICT) ? qtail[vic] : (from_fresh ? fresh[AW-1:0] : free_head);
    slot_we    = 1'b0;
    slot_wa    = new_slot;
    nl_we      = 1'b0;
    nl_wa      = qtail[cidx];
    nl_wd      = new_slot;
    total_next = total;
    if (state == S_WB && out_free) begin
      case (act)
        A_APPEND: begin
          slot_we    = 1'b1;
          nl_we      = qcnt[cidx] != '0;
          total_next = total + 1'b1;
        end
        A_EVICT: begin
          slot_we = 1'b1;
          nl_we   = qcnt[cidx] != '0;
        end
        A_DEQ: begin
          nl_we      = 1'b1;
          nl_wa      = qhead[cidx];
          nl_wd      = free_head;
          total_next = total - 1'b1;
        end
        default: begin
          nl_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      hs_mem[slot_wa] <= in_h;
      pl_mem[slot_wa] <= qtail[cidx];
    end
    hs_rd <= hs_mem[slot_ra];
    pl_rd <= pl_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (nl_we) begin
      nl_mem[nl_wa] <= nl_wd;
    end
    nl_rd <= nl_mem[nl_ra];
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_cls <= s_tdata[CLS_W-1:0];
      in_h   <= s_tdata[CLS_W +: HANDLE_BITS];
      in_sel <= s_tdata[CLS_W+HANDLE_BITS +: SEL_W];
    end
    if (state == S_RD) begin
      act      <= act_next;
      sts      <= sts_next;
      cidx     <= c_idx;
      vic      <= vic_sel;
      stat_val <= stat_next;
    end
    if (state == S_WB && out_free) begin
      o_sts  <= sts;
      o_evc  <= (act == A_EVICT) ? vic : 3'd0;
      o_evh  <= (act == A_EVICT) ? hs_rd : '0;
      o_dqh  <= (act == A_DEQ) ? hs_rd : '0;
      o_stat <= stat_val;
      o_occ  <= OCC_W'(total_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      capacity  <= CFG_W'(1000);
      total     <= '0;
      fresh     <= '0;
      free_head <= '0;
      pulls     <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        share[c]    <= CFG_W'(200);
        qhead[c]    <= '0;
        qtail[c]    <= '0;
        qcnt[c]     <= '0;
        drops[c]    <= '0;
        arrivals[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index) inside
          REG_CAPACITY:             capacity <= cfg_data;
          [REG_SHARE1:REG_SHARE5]:  share[3'(cfg_index - REG_SHARE1)] <= cfg_data;
          default:                  capacity <= capacity;
        endcase
      end
      if (state == S_WB && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_WB;
        end
        S_WB: begin
          if (out_free) begin
            state    <= S_IDLE;
            total    <= total_next;
            case (act)
              A_APPEND: begin
                arrivals[cidx] <= arrivals[cidx] + 1'b1;
                if (from_fresh) begin
                  fresh <= fresh + 1'b1;
                end else begin
                  free_head <= nl_rd;
                end
                if (qcnt[cidx] == '0) begin
                  qhead[cidx] <= new_slot;
                end
                qtail[cidx] <= new_slot;
                qcnt[cidx]  <= qcnt[cidx] + 1'b1;
              end
              A_EVICT: begin
                // The victim's tail slot is reused for the arrival.
                arrivals[cidx] <= arrivals[cidx] + 1'b1;
                drops[vic]     <= drops[vic] + 1'b1;
                if (qcnt[cidx] == '0) begin
                  qhead[cidx] <= new_slot;
                end
                qtail[cidx] <= new_slot;
                qcnt[cidx]  <= qcnt[cidx] + 1'b1;
                qcnt[vic]   <= qcnt[vic] - 1'b1;
                if (qcnt[vic] == CNTW'(1)) begin
                  qhead[vic] <= '0;
                  qtail[vic] <= '0;
                end else begin
                  qtail[vic] <= pl_rd;
                end
              end
              A_DROP: begin
                arrivals[cidx] <= arrivals[cidx] + 1'b1;
                drops[cidx]    <= drops[cidx] + 1'b1;
              end
              A_DEQ: begin
                pulls      <= pulls + 1'b1;
                free_head  <= qhead[cidx];
                qcnt[cidx] <= qcnt[cidx] - 1'b1;
                if (qcnt[cidx] == CNTW'(1)) begin
                  qhead[cidx] <= '0;
                  qtail[cidx] <= '0;
                end else begin
                  qhead[cidx] <= nl_rd;
                end
              end
              A_PULL: begin
                pulls <= pulls + 1'b1;
              end
              default: begin
                pulls <= pulls;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tuser  = o_sts;
  assign m_tdata  = OUT_TW'({o_occ, o_stat, o_dqh, o_evh, o_evc});

endmodule

/* rtl/core/sbpa_checker.sv */
// Port-level checker for the shared-buffer push-out admission block, with its bind.
module sbpa_checker import sbpa_pkg::*; #(
  parameter int HANDLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((CLS_W+2*HANDLE_BITS+STAT_W+OCC_W+7)/8)*8-1:0] m_tdata,
  input logic [STS_W-1:0] m_tuser
);

  // A request occupies the block until it has been written back.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in progress");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // Only a push-out names a victim class.
  a_victim_only_on_evict: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STS_EVICTED)) |-> (m_tdata[CLS_W-1:0] == '0))
    else $error("victim class reported without a push-out");

endmodule

bind shared_buffer_pushout_admission sbpa_checker #(.HANDLE_BITS(HANDLE_BITS)) u_sbpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* test/shared_buffer_pushout_admission_tb.sv */
// Self-checking testbench of the shared-buffer push-out admission block.
module shared_buffer_pushout_admission_tb import sbpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 1024;
  localparam int HB        = 16;
  localparam int IN_W      = ((CLS_W + HB + SEL_W + 7) / 8) * 8;
  localparam int OUT_W     = ((CLS_W + 2 * HB + STAT_W + OCC_W + 7) / 8) * 8;
  localparam int STALL_MAX = 20000;

  typedef struct packed {
    sts_t                status;
    logic [OCC_W-1:0]    occupancy;
    logic [STAT_W-1:0]   stat;
    logic [HB-1:0]       dq_handle;
    logic [HB-1:0]       ev_handle;
    logic [CLS_W-1:0]    ev_cls;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [STS_W-1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  shared_buffer_pushout_admission i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: per-class FIFOs of handles plus counters.
  logic [CFG_W-1:0] capacity_reg;
  logic [CFG_W-1:0] share_reg [NUM_CLASSES];
  logic [HB-1:0] class_fifo [NUM_CLASSES][$];
  logic [31:0] drops [NUM_CLASSES];
  logic [31:0] arrivals [NUM_CLASSES];
  logic [31:0] pulls;

  verdict_t awaited[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  function automatic int held_total();
    int t = 0;
    for (int c = 0; c < NUM_CLASSES; c++) t += class_fifo[c].size();
    return t;
  endfunction

  function automatic verdict_t admit(logic [OP_W-1:0] op, cls_t cls, logic [HB-1:0] h,
                                     logic [SEL_W-1:0] sel);
    verdict_t r;
    int cap;
    int victim;
    r = '0;
    cap = (capacity_reg < DEPTH) ? capacity_reg : DEPTH;
    if (op == OP_ENQ) begin
      r.status = STS_DROPPED;
      if (cls < NUM_CLASSES) begin
        arrivals[cls]++;
        if (held_total() < cap) begin
          class_fifo[cls].push_back(h);
          r.status = STS_STORED;
        end else if (class_fifo[cls].size() >= share_reg[cls]) begin
          drops[cls]++;
        end else begin
          victim = -1;
          for (int v = NUM_CLASSES - 1; v >= 1; v--)
            if (victim < 0 && v != cls && class_fifo[v].size() > share_reg[v]) victim = v;
          if (victim < 0 && cls != 0 && class_fifo[0].size() > 0) victim = 0;
          if (victim < 0) begin
            drops[cls]++;
          end else begin
            r.ev_handle = class_fifo[victim].pop_back();
            drops[victim]++;
            r.ev_cls = CLS_W'(victim);
            class_fifo[cls].push_back(h);
            r.status = STS_EVICTED;
          end
        end
      end
    end else if (op == OP_DEQ) begin
      r.status = STS_EMPTY;
      if (cls < NUM_CLASSES) begin
        pulls++;
        if (class_fifo[cls].size() > 0) begin
          r.dq_handle = class_fifo[cls].pop_front();
          r.status = STS_DEQUEUED;
        end
      end
    end else begin
      r.status = STS_STAT;
      if (op == OP_STAT) begin
        if (sel < 5) r.stat = STAT_W'(class_fifo[sel].size());
        else if (sel < 10) r.stat = drops[sel - 5];
        else if (sel < 15) r.stat = arrivals[sel - 10];
        else r.stat = pulls;
      end
    end
    r.occupancy = OCC_W'(held_total());
    return r;
  endfunction

  task automatic send(logic [OP_W-1:0] op, cls_t cls, logic [HB-1:0] h,
                      logic [SEL_W-1:0] sel);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_W'({sel, h, cls});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    awaited.push_back(admit(op, cls, h, sel));
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (awaited.size() > 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) capacity_reg = val;
    else share_reg[idx - REG_SHARE1] = val;
    @(negedge clk);
  endtask

  task automatic set_shares(int a, int b, int c, int d, int e);
    write_reg(REG_SHARE1, CFG_W'(a));
    write_reg(CFG_IDX_W'(REG_SHARE1 + 1), CFG_W'(b));
    write_reg(CFG_IDX_W'(REG_SHARE1 + 2), CFG_W'(c));
    write_reg(CFG_IDX_W'(REG_SHARE1 + 3), CFG_W'(d));
    write_reg(REG_SHARE5, CFG_W'(e));
  endtask

  task automatic rand_item(int busy);
    int pick;
    pick = $urandom_range(99);
    if (pick < busy)
      send(OP_ENQ, cls_t'($urandom_range(pick < 3 ? 7 : 4)), HB'($urandom),
           SEL_W'($urandom));
    else if (pick < 90)
      send(OP_DEQ, cls_t'($urandom_range(pick > 87 ? 7 : 4)), HB'($urandom),
           SEL_W'($urandom));
    else
      send(OP_W'($urandom_range(pick > 98 ? 3 : 2)), cls_t'($urandom), HB'($urandom),
           SEL_W'($urandom));
  endtask

  task automatic test_directed();
    send(OP_STAT, 0, 16'h0000, 4'd15);
    send(OP_DEQ, 2, 16'hFFFF, 4'd0);
    send(OP_ENQ, 0, 16'h0000, 4'd0);
    send(OP_ENQ, 4, 16'hFFFF, 4'd0);
    send(OP_ENQ, 7, 16'h1234, 4'd0);
    send(OP_DEQ, 6, 16'h0, 4'd0);
    send(3, 0, 16'h0, 4'd0);
    send(OP_DEQ, 0, 16'h0, 4'd0);
    send(OP_DEQ, 0, 16'h0, 4'd0);
    for (int s = 0; s < 16; s++) send(OP_STAT, 7, 16'h0, SEL_W'(s));
    drain();
  endtask

  // Small capacity with varied shares: pushes out over-share classes and class 0.
  task automatic test_pushout(int cap, int busy, int count);
    write_reg(REG_CAPACITY, CFG_W'(cap));
    set_shares($urandom_range(3), $urandom_range(4), $urandom_range(4),
               $urandom_range(4), $urandom_range(5));
    for (int i = 0; i < count; i++) rand_item(busy);
    drain();
  endtask

  // Capacity zero with extreme shares, then the largest capacity.
  task automatic test_extremes();
    write_reg(REG_CAPACITY, 0);
    set_shares(0, 11'h7FF, 1, 0, 11'h7FF);
    for (int i = 0; i < 20; i++) send(OP_ENQ, cls_t'($urandom_range(4)), HB'($urandom), 0);
    drain();
    write_reg(REG_CAPACITY, 11'h7FF);
    for (int i = 0; i < 30; i++) rand_item(70);
    drain();
  endtask

  // Send enqueues while the receiver is held off.
  task automatic test_backpressure();
    write_reg(REG_CAPACITY, 1000);
    set_shares(200, 200, 200, 200, 200);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send(OP_ENQ, cls_t'($urandom_range(4)), HB'($urandom), 0);
    join
    drain();
  endtask

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[CLS_W+2*HB+STAT_W+OCC_W-1:0]};
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status || got.ev_cls !== want.ev_cls ||
            got.ev_handle !== want.ev_handle || got.dq_handle !== want.dq_handle ||
            got.stat !== want.stat || got.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected sts=%0d cls=%0d ev=%h dq=%h stat=%0d occ=%0d",
                     want.status, want.ev_cls, want.ev_handle, want.dq_handle, want.stat,
                     want.occupancy);
            $display("          got sts=%0d cls=%0d ev=%h dq=%h stat=%0d occ=%0d",
                     got.status, got.ev_cls, got.ev_handle, got.dq_handle, got.stat,
                     got.occupancy);
          end
        end
      end
    end
  end

  always @(negedge clk)
    m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("[shared_buffer_pushout_admission] ERROR");
      $finish;
    end
  end

  initial begin
    capacity_reg = 1000;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      share_reg[c] = 200;
      drops[c]     = 0;
      arrivals[c]  = 0;
    end
    pulls = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 36;
    recv_idle_pct = 60;
    test_pushout(6, 65, 160);
    test_extremes();
    send_idle_pct = 60;
    recv_idle_pct = 36;
    test_pushout(1, 60, 120);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_pushout(12, 62, 160);
    drain();
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("[shared_buffer_pushout_admission] OK");
    end else begin
      $display("[shared_buffer_pushout_admission] ERROR");
    end
    $finish;
  end
endmodule
